// File: design/keyframe_track_sampler_core_defines.svh
// assertion macros for the keyframe track sampler
`ifndef KEYFRAME_TRACK_SAMPLER_CORE_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication on clk, off while in reset
`define KTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off while in reset
`define KTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kts_pkg.sv
// shared types, constants and helpers for the keyframe track sampler
`default_nettype none

package kts_pkg;

    localparam int KEYS   = 16;
    localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CNT_W  = $clog2(KEYS + 1);
    localparam int FRAC_W = 16;
    localparam int CFG_AW = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] EASE_LINEAR = 2'd0;
    localparam logic [1:0] EASE_IN     = 2'd1;
    localparam logic [1:0] EASE_OUT    = 2'd2;
    localparam logic [1:0] EASE_IN_OUT = 2'd3;

    localparam logic [CFG_AW-1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_EMPTY_X   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_EMPTY_Y   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_EMPTY_Z   = 2'd3;

    typedef struct packed {
        logic               op;
        logic [3:0]         key_index;
        logic [31:0]        key_time;
        logic [1:0]         key_ease;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [31:0]        sample_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        key_time;
        logic [1:0]         ease;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } key_entry_t;

    typedef enum logic {
        MUL_EASE,
        MUL_COMP
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t           sel;
        logic [1:0]         mode;
        logic [FRAC_W-1:0]  f;
        logic signed [32:0] diff;
        logic [FRAC_W-1:0]  e;
    } mul_req_t;

    // a + floor(prod / 65536), clamped to the signed 32-bit range
    function automatic logic signed [31:0] lerp_sat(input logic signed [31:0] a,
                                                    input logic signed [52:0] prod);
        logic signed [52:0] sh;
        logic signed [36:0] r;
        sh = prod >>> 16;
        r  = $signed({{5{a[31]}}, a}) + sh[36:0];
        if (!r[36] && (r[35:31] != 5'b00000))
            lerp_sat = 32'sh7fff_ffff;
        else if (r[36] && (r[35:31] != 5'b11111))
            lerp_sat = 32'sh8000_0000;
        else
            lerp_sat = r[31:0];
    endfunction

endpackage

`default_nettype wire

// File: design/kts_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/kts_div.sv
// serial restoring divider for the segment fraction, one quotient bit per cycle
`default_nettype none

module kts_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [31:0]               num,
    input  wire logic [31:0]               den,
    output logic                           done,
    output logic [kts_pkg::FRAC_W-1:0]     quo
);

    localparam int STEP_W = $clog2(kts_pkg::FRAC_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [31:0]                 rem_reg, rem_next;
    logic [31:0]                 den_reg, den_next;
    logic [kts_pkg::FRAC_W-1:0]  quo_reg, quo_next;
    logic [32:0]                 shifted;
    logic [32:0]                 diff;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so the compare fits in 33 bits
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[kts_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[kts_pkg::FRAC_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(kts_pkg::FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: design/kts_mul.sv
// shared multiplier for easing and component interpolation, registered product
`default_nettype none

module kts_mul (
    input  wire logic                       clk,
    input  wire kts_pkg::mul_req_t          req,
    output logic signed [52:0]              prod,
    output logic [kts_pkg::FRAC_W-1:0]      ease_val
);

    logic signed [33:0] op_a;
    logic signed [18:0] op_b;
    logic signed [52:0] prod_reg;
    logic [15:0]        s_val;
    logic [47:0]        upper_sum;

    assign s_val = {req.f[14:0], 1'b0};

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (req.sel)
            kts_pkg::MUL_EASE:
            begin
                unique case (req.mode)
                    kts_pkg::EASE_LINEAR:
                    begin
                        op_a = $signed({18'd0, req.f});
                        op_b = 19'sd65536;
                    end
                    kts_pkg::EASE_IN:
                    begin
                        op_a = $signed({18'd0, req.f});
                        op_b = $signed({3'd0, req.f});
                    end
                    kts_pkg::EASE_OUT:
                    begin
                        op_a = $signed({18'd0, req.f});
                        op_b = 19'sd131072 - $signed({3'd0, req.f});
                    end
                    kts_pkg::EASE_IN_OUT:
                    begin
                        if (!req.f[15])
                        begin
                            op_a = $signed({18'd0, req.f});
                            op_b = $signed({3'd0, s_val});
                        end
                        else
                        begin
                            op_a = $signed({18'd0, s_val});
                            op_b = 19'sd131072 - $signed({3'd0, s_val});
                        end
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            kts_pkg::MUL_COMP:
            begin
                op_a = {req.diff[32], req.diff};
                op_b = $signed({3'd0, req.e});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // second half of ease in-out adds one full square before the final shift
    assign upper_sum = prod_reg[47:0] + 48'h0001_0000_0000;

    always_comb
    begin
        if ((req.mode == kts_pkg::EASE_IN_OUT) && req.f[15])
            ease_val = upper_sum[32:17];
        else
            ease_val = prod_reg[31:16];
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: design/keyframe_track_sampler_core.sv
// top level of the keyframe track sampler: config registers, sequencer, key table
`default_nettype none

`include "keyframe_track_sampler_core_defines.svh"

// A key write goes straight into the key table. A sample scans the key table one
// entry per cycle through the table ram's single read port, up to the effective key
// count (key_count capped at 16). It then runs the serial divider for the segment
// fraction and the shared multiplier for easing and the three components (states
// ST_EASE, ST_EASE2, ST_LX, ST_LY, ST_LZ, ST_LW). in_stall stays high until the
// sequencer is back in ST_IDLE, so the next transaction waits for the sample. An
// empty-table sample goes straight to ST_FIN; a sample before the first key or after
// the last key goes from the scan to ST_FIN. The finished result sits in an output
// register, and a new transaction is accepted while it waits to be taken;
// a later sample then waits at its end until the output register is free.
module keyframe_track_sampler_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire kts_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output kts_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_we,
    input  wire logic [kts_pkg::CFG_AW-1:0]      cfg_index,
    input  wire logic [31:0]                     cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SEARCH = 10'b00_0000_0010,
        ST_DIV    = 10'b00_0000_0100,
        ST_EASE   = 10'b00_0000_1000,
        ST_EASE2  = 10'b00_0001_0000,
        ST_LX     = 10'b00_0010_0000,
        ST_LY     = 10'b00_0100_0000,
        ST_LZ     = 10'b00_1000_0000,
        ST_LW     = 10'b01_0000_0000,
        ST_FIN    = 10'b10_0000_0000
    } state_t;

    state_t                           state_reg, state_next;
    logic [4:0]                       count_reg;
    logic signed [31:0]               empty_x_reg, empty_y_reg, empty_z_reg;
    logic [kts_pkg::KEY_AW-1:0]       idx_reg, idx_next;
    logic [kts_pkg::CNT_W-1:0]        n_reg, n_next, n_eff;
    logic [31:0]                      t_reg, t_next;
    kts_pkg::key_entry_t              prev_reg, prev_next;
    kts_pkg::key_entry_t              cur_reg, cur_next;
    logic [kts_pkg::FRAC_W-1:0]       f_reg, f_next;
    logic [kts_pkg::FRAC_W-1:0]       e_reg, e_next;
    kts_pkg::out_item_t               res_reg, res_next;
    kts_pkg::out_item_t               out_reg, out_next;
    logic                             out_valid_reg, out_valid_next;

    logic                             in_take;
    logic                             sample_take;
    logic                             fin_move;
    logic                             ram_we;
    kts_pkg::key_entry_t              ram_wdata;
    kts_pkg::key_entry_t              ram_rdata;
    logic                             div_start;
    logic                             div_done;
    logic [kts_pkg::FRAC_W-1:0]       div_quo;
    kts_pkg::mul_req_t                mul_req;
    logic signed [52:0]               mul_prod;
    logic [kts_pkg::FRAC_W-1:0]       ease_val;
    logic                             out_free;
    logic                             is_last;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign sample_take = in_take && (in_data.op == kts_pkg::OP_SAMPLE);
    assign out_valid   = out_valid_reg;
    assign out_data    = out_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign fin_move    = (state_reg == ST_FIN) && out_free;

    assign n_eff = (32'(count_reg) > kts_pkg::KEYS) ? kts_pkg::CNT_W'(kts_pkg::KEYS)
                                                    : kts_pkg::CNT_W'(count_reg);
    assign is_last = ((kts_pkg::CNT_W'(idx_reg) + 1'b1) == n_reg);

    assign ram_we = in_take && (in_data.op == kts_pkg::OP_WRITE)
                    && (32'(in_data.key_index) < kts_pkg::KEYS);
    assign ram_wdata.key_time = in_data.key_time;
    assign ram_wdata.ease     = in_data.key_ease;
    assign ram_wdata.x        = in_data.key_x;
    assign ram_wdata.y        = in_data.key_y;
    assign ram_wdata.z        = in_data.key_z;

    kts_ram #(
        .WIDTH($bits(kts_pkg::key_entry_t)),
        .DEPTH(kts_pkg::KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (kts_pkg::KEY_AW'(in_data.key_index)),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    kts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (t_reg - prev_reg.key_time),
        .den   (ram_rdata.key_time - prev_reg.key_time),
        .done  (div_done),
        .quo   (div_quo)
    );

    kts_mul u_mul (
        .clk      (clk),
        .req      (mul_req),
        .prod     (mul_prod),
        .ease_val (ease_val)
    );

    always_comb
    begin
        mul_req.sel  = kts_pkg::MUL_COMP;
        mul_req.mode = cur_reg.ease;
        mul_req.f    = f_reg;
        mul_req.e    = e_reg;
        mul_req.diff = {cur_reg.x[31], cur_reg.x} - {prev_reg.x[31], prev_reg.x};
        if ((state_reg == ST_EASE) || (state_reg == ST_EASE2))
            mul_req.sel = kts_pkg::MUL_EASE;
        else if (state_reg == ST_LY)
            mul_req.diff = {cur_reg.y[31], cur_reg.y} - {prev_reg.y[31], prev_reg.y};
        else if (state_reg == ST_LZ)
            mul_req.diff = {cur_reg.z[31], cur_reg.z} - {prev_reg.z[31], prev_reg.z};
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        f_next         = f_reg;
        e_next         = e_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (in_data.op == kts_pkg::OP_SAMPLE))
                begin
                    t_next   = in_data.sample_time;
                    n_next   = n_eff;
                    idx_next = '0;
                    if (n_eff == '0)
                    begin
                        res_next.out_x = empty_x_reg;
                        res_next.out_y = empty_y_reg;
                        res_next.out_z = empty_z_reg;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (t_reg < ram_rdata.key_time)
                begin
                    if (idx_reg == '0)
                    begin
                        res_next.out_x = ram_rdata.x;
                        res_next.out_y = ram_rdata.y;
                        res_next.out_z = ram_rdata.z;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        cur_next   = ram_rdata;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else if (is_last)
                begin
                    res_next.out_x = ram_rdata.x;
                    res_next.out_y = ram_rdata.y;
                    res_next.out_z = ram_rdata.z;
                    state_next     = ST_FIN;
                end
                else
                begin
                    prev_next = ram_rdata;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    f_next     = div_quo;
                    state_next = ST_EASE;
                end
            end
            ST_EASE:
            begin
                state_next = ST_EASE2;
            end
            ST_EASE2:
            begin
                e_next     = ease_val;
                state_next = ST_LX;
            end
            ST_LX:
            begin
                state_next = ST_LY;
            end
            ST_LY:
            begin
                res_next.out_x = kts_pkg::lerp_sat(prev_reg.x, mul_prod);
                state_next     = ST_LZ;
            end
            ST_LZ:
            begin
                res_next.out_y = kts_pkg::lerp_sat(prev_reg.y, mul_prod);
                state_next     = ST_LW;
            end
            ST_LW:
            begin
                res_next.out_z = kts_pkg::lerp_sat(prev_reg.z, mul_prod);
                state_next     = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
            count_reg     <= '0;
            empty_x_reg   <= '0;
            empty_y_reg   <= '0;
            empty_z_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kts_pkg::REG_KEY_COUNT: count_reg   <= cfg_data[4:0];
                    kts_pkg::REG_EMPTY_X:   empty_x_reg <= cfg_data;
                    kts_pkg::REG_EMPTY_Y:   empty_y_reg <= cfg_data;
                    kts_pkg::REG_EMPTY_Z:   empty_z_reg <= cfg_data;
                    default:                count_reg   <= count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        f_reg    <= f_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    `KTS_ASSERT_NEXT(a_empty_to_fin, sample_take && (n_eff == '0), state_reg == ST_FIN, "empty skip")
    `KTS_ASSERT_NOW(a_div_in_div, div_done, state_reg == ST_DIV, "divider done outside divide")
    `KTS_ASSERT_NEXT(a_fin_loads_out, fin_move, out_valid && state_reg == ST_IDLE, "not loaded")
    `KTS_ASSERT_NOW(a_search_nonempty, state_reg == ST_SEARCH, n_reg != '0, "empty search")

endmodule

`default_nettype wire
